### hw/rtl/wave_pcm_header_parser_unit_defines.svh
// Assertion macros for the WAVE header parser.
`ifndef WAVE_PCM_HEADER_PARSER_UNIT_DEFINES_SVH
`define WAVE_PCM_HEADER_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WPH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WPH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPH_ASSERT(label, clk, rst_n, prop, msg)
`define WPH_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hw/rtl/wph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wph_pkg;
  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;
  localparam logic [15:0] SCAN_LIMIT_RST = 16'd4096;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PCM = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  // phases 0..10 are the header fields in file order
  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_FMT   = 4'd3,
    PH_FSIZE = 4'd4,
    PH_FTAG  = 4'd5,
    PH_CHAN  = 4'd6,
    PH_RATE  = 4'd7,
    PH_BRATE = 4'd8,
    PH_ALIGN = 4'd9,
    PH_BITS  = 4'd10,
    PH_SCAN  = 4'd11,
    PH_DSIZE = 4'd12,
    PH_PCM   = 4'd13,
    PH_IDLE  = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_DIV  = 3'd1,
    ST_HOLD = 3'd2
  } ctl_state_t;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ERR_SCAN      = 4'd12;
  localparam logic [3:0] ERR_DSIZE     = 4'd13;
  localparam logic [3:0] ERR_OFFSET    = 4'd14;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] chunk_bytes;
    logic [31:0] pcm_start;
    logic [34:0] num_samples;
    logic [28:0] bytes_per_sample;
    logic [7:0]  pcm_byte;
    logic        last_byte;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic step;      // process one input word
    logic restart;   // first_byte seen
    logic div_start;
    logic div_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic res_now;   // this word yields a result (no division)
    logic hdr_now;   // this word completes a good header (division needed)
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

### hw/rtl/wph_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;
  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink (input valid, input file_byte, input first_byte, output ready);
endinterface

interface wph_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  status;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [31:0] chunk_bytes;
  logic [31:0] pcm_start;
  logic [34:0] num_samples;
  logic [28:0] bytes_per_sample;
  logic [7:0]  pcm_byte;
  logic        last_byte;
  modport source (output valid, output kind, output status, output channels,
    output sample_rate, output block_align, output bits_per_sample, output chunk_bytes,
    output pcm_start, output num_samples, output bytes_per_sample, output pcm_byte,
    output last_byte, input ready);
  modport sink (input valid, input kind, input status, input channels,
    input sample_rate, input block_align, input bits_per_sample, input chunk_bytes,
    input pcm_start, input num_samples, input bytes_per_sample, input pcm_byte,
    input last_byte, output ready);
endinterface
`default_nettype wire

### hw/rtl/wph_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module wph_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wph_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]       file_byte,
  input  wire logic [15:0]      scan_limit,
  output wph_pkg::dp_sts_t      sts,
  output wph_pkg::result_t      res
);
  import wph_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [2:0]  shift_r, shift_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] win_r, win_nxt;
  logic [15:0] scan_r, scan_nxt;
  logic [31:0] dsz_r, dsz_nxt;
  logic [31:0] rem_r, rem_nxt;

  // restart view of state
  phase_t      ph;
  logic [31:0] pos0, riff0, win0, rem0;
  logic [2:0]  sh0;
  logic [15:0] scan0;
  logic [31:0] win_sh, pos_inc, v, fld;
  logic [2:0]  sh_inc;
  logic        two_byte, ok;

  // divider: num = 8*ds (35b) / prod (32b), restoring, one bit a cycle
  logic [34:0] dq_r, dq_nxt;
  logic [32:0] drem_r, drem_nxt;
  logic [31:0] dden_r, dden_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [32:0] dtrial;
  logic [32:0] dsub;

  result_t res_r, res_nxt;

  always_comb begin
    ph    = cmd.restart ? PH_RIFF : phase_r;
    pos0  = cmd.restart ? 32'd0 : pos_r;
    riff0 = cmd.restart ? 32'd0 : riff_r;
    win0  = cmd.restart ? 32'd0 : win_r;
    sh0   = cmd.restart ? 3'd0 : shift_r;
    scan0 = cmd.restart ? 16'd0 : scan_r;
    rem0  = cmd.restart ? 32'd0 : rem_r;
    win_sh  = {file_byte, win0[31:8]};
    pos_inc = pos0 + 32'd1;
    sh_inc  = sh0 + 3'd1;
    two_byte = (ph == PH_FTAG) || (ph == PH_CHAN) || (ph == PH_ALIGN) || (ph == PH_BITS);
    v = two_byte ? {16'd0, win_sh[31:16]} : win_sh;
    fld = v;

    phase_nxt = phase_r; pos_nxt = pos_r; shift_nxt = shift_r; riff_nxt = riff_r;
    chan_nxt = chan_r; rate_nxt = rate_r; align_nxt = align_r; bits_nxt = bits_r;
    win_nxt = win_r; scan_nxt = scan_r; dsz_nxt = dsz_r; rem_nxt = rem_r;
    res_nxt = res_r;
    sts = '0;
    sts.div_done = (dcnt_r == 6'd0);
    ok = 1'b1;

    if (cmd.step) begin
      if (cmd.restart) begin
        phase_nxt = PH_RIFF; pos_nxt = '0; shift_nxt = '0; riff_nxt = '0;
        chan_nxt = '0; rate_nxt = '0; align_nxt = '0; bits_nxt = '0;
        win_nxt = '0; scan_nxt = '0; dsz_nxt = '0; rem_nxt = '0;
      end
      res_nxt = '0;
      case (ph)
        PH_IDLE: ;
        PH_PCM: begin
          sts.res_now = 1'b1;
          res_nxt.kind = KIND_PCM;
          res_nxt.pcm_byte = file_byte;
          rem_nxt = rem0 - 32'd1;
          if (rem0 == 32'd1) begin
            res_nxt.last_byte = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SCAN: begin
          win_nxt = win_sh;
          pos_nxt = pos_inc;
          if (sh0 < 3'd4) shift_nxt = sh_inc;
          if (sh0 >= 3'd3) begin
            if (win_sh == TAG_DATA) begin
              win_nxt = '0; shift_nxt = '0; phase_nxt = PH_DSIZE;
            end else if (scan0 >= scan_limit) begin
              sts.res_now = 1'b1;
              res_nxt.kind = KIND_ERR; res_nxt.status = ERR_SCAN;
              phase_nxt = PH_IDLE;
            end else begin
              scan_nxt = scan0 + 16'd1;
            end
          end
        end
        PH_DSIZE: begin
          win_nxt = win_sh;
          pos_nxt = pos_inc;
          shift_nxt = sh_inc;
          if (sh0 == 3'd3) begin
            dsz_nxt = win_sh;
            if (win_sh == 32'd0) begin
              sts.res_now = 1'b1;
              res_nxt.kind = KIND_ERR; res_nxt.status = ERR_DSIZE;
              phase_nxt = PH_IDLE;
            end else if (riff0 - win_sh + 32'd8 != pos_inc) begin
              sts.res_now = 1'b1;
              res_nxt.kind = KIND_ERR; res_nxt.status = ERR_OFFSET;
              phase_nxt = PH_IDLE;
            end else begin
              sts.hdr_now = 1'b1;
              res_nxt.kind = KIND_HDR;
              res_nxt.channels = chan_r;
              res_nxt.sample_rate = rate_r;
              res_nxt.block_align = align_r;
              res_nxt.bits_per_sample = bits_r;
              res_nxt.chunk_bytes = win_sh;
              res_nxt.pcm_start = pos_inc;
              rem_nxt = win_sh;
              win_nxt = '0; shift_nxt = '0; phase_nxt = PH_PCM;
            end
          end
        end
        default: begin
          win_nxt = win_sh;
          pos_nxt = pos_inc;
          shift_nxt = sh_inc;
          if ((two_byte && sh0 == 3'd1) || (!two_byte && sh0 == 3'd3)) begin
            win_nxt = '0; shift_nxt = '0;
            case (ph)
              PH_RIFF:  ok = (fld == TAG_RIFF);
              PH_RSIZE: begin ok = (fld != 0); riff_nxt = fld; end
              PH_WAVE:  ok = (fld == TAG_WAVE);
              PH_FMT:   ok = (fld == TAG_FMT);
              PH_FSIZE: ok = (fld == 32'd16);
              PH_FTAG:  ok = (fld == 32'd1);
              PH_CHAN:  begin ok = (fld != 0); chan_nxt = fld[15:0]; end
              PH_RATE:  begin ok = (fld != 0); rate_nxt = fld; end
              PH_BRATE: ok = (fld != 0);
              PH_ALIGN: begin ok = (fld != 0); align_nxt = fld[15:0]; end
              default:  begin ok = (fld != 0); bits_nxt = fld[15:0]; end
            endcase
            if (!ok) begin
              sts.res_now = 1'b1;
              res_nxt.kind = KIND_ERR;
              res_nxt.status = ph + 4'd1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = phase_t'(ph + 4'd1);
              if (ph == PH_BITS) scan_nxt = '0;
            end
          end
        end
      endcase
    end
  end

  // divider and product
  always_comb begin
    dq_nxt = dq_r; drem_nxt = drem_r; dden_nxt = dden_r; dcnt_nxt = dcnt_r;
    prod_nxt = prod_r;
    dtrial = {drem_r[31:0], dq_r[34]};
    dsub = dtrial - {1'b0, dden_r};
    if (cmd.div_start) begin
      prod_nxt = 32'(res_r.channels) * 32'(res_r.bits_per_sample);
      dden_nxt = 32'(res_r.channels) * 32'(res_r.bits_per_sample);
      dq_nxt = {dsz_r, 3'b000};
      drem_nxt = '0;
      dcnt_nxt = 6'd35;
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      if (!dsub[32]) begin
        drem_nxt = dsub;
        dq_nxt = {dq_r[33:0], 1'b1};
      end else begin
        drem_nxt = dtrial;
        dq_nxt = {dq_r[33:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 6'd1;
    end
  end

  always_comb begin
    res = res_r;
    res.num_samples = '0;
    res.bytes_per_sample = '0;
    if (res_r.kind == KIND_HDR) begin
      res.num_samples = (prod_r == 32'd0) ? 35'd0 : dq_r;
      res.bytes_per_sample = prod_r[31:3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF; pos_r <= '0; shift_r <= '0; riff_r <= '0;
      chan_r <= '0; rate_r <= '0; align_r <= '0; bits_r <= '0;
      win_r <= '0; scan_r <= '0; dsz_r <= '0; rem_r <= '0;
      dcnt_r <= '0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; shift_r <= shift_nxt; riff_r <= riff_nxt;
      chan_r <= chan_nxt; rate_r <= rate_nxt; align_r <= align_nxt; bits_r <= bits_nxt;
      win_r <= win_nxt; scan_r <= scan_nxt; dsz_r <= dsz_nxt; rem_r <= rem_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dden_r <= dden_nxt; prod_r <= prod_nxt;
  end
endmodule
`default_nettype wire

### hw/rtl/wph_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wave_pcm_header_parser_unit_defines.svh"
module wph_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_first,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire wph_pkg::dp_sts_t sts,
  output wph_pkg::dp_cmd_t      cmd
);
  import wph_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_RUN: begin
        // take a word only when the result register is free or draining
        in_ready = !ov_r || out_ready;
        cmd.step = in_valid && in_ready;
        cmd.restart = in_first;
        if (cmd.step) begin
          if (sts.hdr_now) state_nxt = ST_HOLD;
          else if (sts.res_now) ov_nxt = 1'b1;
        end
      end
      ST_HOLD: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          ov_nxt = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  `WPH_ASSERT(a_busy_no_take, clk, rst_n, (state_r != ST_RUN) |-> !in_ready, "word taken during division")
  `WPH_ASSERT(a_hold_keeps, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `WPH_ASSERT(a_hold_div, clk, rst_n, (state_r == ST_HOLD) |=> (state_r == ST_DIV), "division not started")
endmodule
`default_nettype wire

### hw/rtl/wave_pcm_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// WAVE/PCM header parser. At most one file byte is taken per cycle; every
// byte is taken only while the result register is free or being drained in
// the same cycle, so a stalled receiver stalls the input. The header result
// needs the sample count 8*chunk_bytes/(channels*bits); a bit-serial divider
// computes it, holding the input off after the last byte of the data chunk
// size (a start state, then the divide state), the only stall the parser
// makes per file. first_byte restarts the parse. Errors give one result,
// then bytes are dropped until a restart. cfg_we writes scan_limit at once.
module wave_pcm_header_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wph_in_if.sink           in_ch,
  wph_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import wph_pkg::*;

  logic [15:0] scan_limit_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) scan_limit_r <= SCAN_LIMIT_RST;
    else if (cfg_we) scan_limit_r <= cfg_wdata;
  end

  wph_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_first(in_ch.first_byte), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  wph_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .file_byte(in_ch.file_byte),
    .scan_limit(scan_limit_r), .sts(sts), .res(res)
  );

  assign out_ch.kind             = res.kind;
  assign out_ch.status           = res.status;
  assign out_ch.channels         = res.channels;
  assign out_ch.sample_rate      = res.sample_rate;
  assign out_ch.block_align      = res.block_align;
  assign out_ch.bits_per_sample  = res.bits_per_sample;
  assign out_ch.chunk_bytes      = res.chunk_bytes;
  assign out_ch.pcm_start        = res.pcm_start;
  assign out_ch.num_samples      = res.num_samples;
  assign out_ch.bytes_per_sample = res.bytes_per_sample;
  assign out_ch.pcm_byte         = res.pcm_byte;
  assign out_ch.last_byte        = res.last_byte;
endmodule
`default_nettype wire
